/* design/obb_sat_pkg.sv */
// shared constants for the oriented-box separating axis test
// no dependencies
`default_nettype none
package obb_sat_pkg;
   localparam int FIELD_WIDTH = 48;
   localparam int NUM_FIELDS = 10;
   localparam int REQ_DATA_WIDTH = FIELD_WIDTH * NUM_FIELDS;
   localparam int RSP_DATA_WIDTH = 8;
   localparam int COMPONENT_WIDTH_DEFAULT = 16;
   localparam int NUM_AXES = 15;
endpackage
`default_nettype wire

/* design/obb_overlap_separating_axis_test_top.sv */
// Oriented-box pair overlap test over the fifteen separating axes, six-stage pipeline.
// depends on obb_sat_pkg
`default_nettype none
// One box pair is taken per clock and its overlap flag is offered after the pair's transfer
// has passed through unpack, projection products, dot-product sums, radius and cross
// products, projection operands and the final compare; the whole pipe holds only while the
// result register is full and not taken.
module obb_overlap_separating_axis_test_top
   import obb_sat_pkg::*;
#(
   parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // a_axis_zero, a_axis_one, a_axis_two, b_axis_zero, b_axis_one, b_axis_two,
   // a_center, b_center, a_half_extent, b_half_extent (48 bits each, lowest first)
   input  wire logic [REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // overlap in bit 0, rest zero
   output logic [RSP_DATA_WIDTH-1:0]      rsp_tdata
);
   localparam int CW = COMPONENT_WIDTH;
   localparam int FRAC = CW - 2;
   localparam int DW = CW + 1;
   localparam int TW = 2 * CW + 3;
   localparam int RW = 2 * CW + 2;
   localparam int EW = 3 * CW + 2;
   localparam int XW = 4 * CW + 5;
   localparam int WD = 4 * CW + 8;
   localparam int PADW = FIELD_WIDTH + 3 * CW;

   logic enable;
   logic [5:0] valid_ff;

   // stage 1
   logic signed [CW-1:0] s1_a_in [3][3], s1_b_in [3][3];
   logic signed [DW-1:0] s1_d_in [3];
   logic [CW-1:0] s1_ea_in [3], s1_eb_in [3];
   logic signed [CW-1:0] s1_a_ff [3][3], s1_b_ff [3][3];
   logic signed [DW-1:0] s1_d_ff [3];
   logic [CW-1:0] s1_ea_ff [3], s1_eb_ff [3];
   // stage 2
   logic signed [2*CW:0] s2_ad_ff [3][3], s2_bd_ff [3][3];
   logic signed [2*CW-1:0] s2_ab_ff [3][3][3];
   logic [CW-1:0] s2_ea_ff [3], s2_eb_ff [3];
   // stage 3
   logic signed [TW-1:0] s3_t_ff [3], s3_p_ff [3];
   logic signed [RW-1:0] s3_rm_ff [3][3];
   logic [CW-1:0] s3_ea_ff [3], s3_eb_ff [3];
   // stage 4
   logic [RW-1:0] s4_rmag [3][3];
   logic signed [TW-1:0] s4_t_ff [3], s4_p_ff [3];
   logic [CW-1:0] s4_ea_ff [3], s4_eb_ff [3];
   logic [EW-1:0] s4_pa_ff [3][3][3], s4_pb_ff [3][3][3];
   logic signed [XW-1:0] s4_cp_ff [3][3][2];
   // stage 5
   logic [WD-1:0] s5_lhs_in [NUM_AXES], s5_rhs_in [NUM_AXES];
   logic [WD-1:0] s5_lhs_ff [NUM_AXES], s5_rhs_ff [NUM_AXES];
   logic overlap_in, overlap_ff;

   assign enable = !valid_ff[5] || rsp_tready;
   assign req_tready = enable;
   assign rsp_tvalid = valid_ff[5];
   assign rsp_tdata = {{(RSP_DATA_WIDTH-1){1'b0}}, overlap_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[4:0], req_tvalid};
      end
   end

   // unpack; component bits above the 48-bit field read as zero
   always_comb begin
      logic [PADW-1:0] padded [NUM_FIELDS];
      for (int f = 0; f < NUM_FIELDS; f++) begin
         padded[f] = PADW'(req_tdata[f*FIELD_WIDTH +: FIELD_WIDTH]);
      end
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            s1_a_in[i][k] = padded[i][k*CW +: CW];
            s1_b_in[i][k] = padded[3+i][k*CW +: CW];
         end
         s1_d_in[i] = DW'(signed'(padded[6][i*CW +: CW]))
                    - DW'(signed'(padded[7][i*CW +: CW]));
         s1_ea_in[i] = padded[8][i*CW +: CW];
         s1_eb_in[i] = padded[9][i*CW +: CW];
      end
   end

   always_comb begin
      for (int y = 0; y < 3; y++) begin
         for (int j = 0; j < 3; j++) begin
            s4_rmag[y][j] = s3_rm_ff[y][j][RW-1] ? RW'(-s3_rm_ff[y][j])
                                                 : RW'(s3_rm_ff[y][j]);
         end
      end
   end

   // projection operands: face axes of a, face axes of b, then cross axes a_i x b_j
   always_comb begin
      logic signed [WD-1:0] tmp;
      int i1, i2, j1, j2;
      for (int i = 0; i < 3; i++) begin
         tmp = WD'(s4_t_ff[i]);
         tmp = tmp[WD-1] ? -tmp : tmp;
         s5_lhs_in[i] = tmp << FRAC;
         s5_rhs_in[i] = (WD'(s4_ea_ff[i]) << (2 * FRAC)) + WD'(s4_pb_ff[i][0][0])
                      + WD'(s4_pb_ff[i][1][1]) + WD'(s4_pb_ff[i][2][2]);
         tmp = WD'(s4_p_ff[i]);
         tmp = tmp[WD-1] ? -tmp : tmp;
         s5_lhs_in[3+i] = tmp << FRAC;
         s5_rhs_in[3+i] = (WD'(s4_eb_ff[i]) << (2 * FRAC)) + WD'(s4_pa_ff[0][0][i])
                        + WD'(s4_pa_ff[1][1][i]) + WD'(s4_pa_ff[2][2][i]);
      end
      for (int i = 0; i < 3; i++) begin
         i1 = (i + 1) % 3;
         i2 = (i + 2) % 3;
         for (int j = 0; j < 3; j++) begin
            j1 = (j + 1) % 3;
            j2 = (j + 2) % 3;
            tmp = WD'(s4_cp_ff[i][j][0]) - WD'(s4_cp_ff[i][j][1]);
            s5_lhs_in[6+i*3+j] = tmp[WD-1] ? -tmp : tmp;
            s5_rhs_in[6+i*3+j] = (WD'(s4_pa_ff[i1][i2][j]) + WD'(s4_pa_ff[i2][i1][j])
                                + WD'(s4_pb_ff[i][j2][j1]) + WD'(s4_pb_ff[i][j1][j2]))
                                << FRAC;
         end
      end
   end

   // touching counts as overlap
   always_comb begin
      overlap_in = 1'b1;
      for (int n = 0; n < NUM_AXES; n++) begin
         if (s5_lhs_ff[n] > s5_rhs_ff[n]) begin
            overlap_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_a_ff <= s1_a_in;
         s1_b_ff <= s1_b_in;
         s1_d_ff <= s1_d_in;
         s1_ea_ff <= s1_ea_in;
         s1_eb_ff <= s1_eb_in;
         s2_ea_ff <= s1_ea_ff;
         s2_eb_ff <= s1_eb_ff;
         s3_ea_ff <= s2_ea_ff;
         s3_eb_ff <= s2_eb_ff;
         s4_ea_ff <= s3_ea_ff;
         s4_eb_ff <= s3_eb_ff;
         s4_t_ff <= s3_t_ff;
         s4_p_ff <= s3_p_ff;
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               s2_ad_ff[i][k] <= s1_a_ff[i][k] * s1_d_ff[k];
               s2_bd_ff[i][k] <= s1_b_ff[i][k] * s1_d_ff[k];
               for (int j = 0; j < 3; j++) begin
                  s2_ab_ff[i][j][k] <= s1_a_ff[i][k] * s1_b_ff[j][k];
               end
            end
            s3_t_ff[i] <= TW'(s2_ad_ff[i][0]) + TW'(s2_ad_ff[i][1]) + TW'(s2_ad_ff[i][2]);
            s3_p_ff[i] <= TW'(s2_bd_ff[i][0]) + TW'(s2_bd_ff[i][1]) + TW'(s2_bd_ff[i][2]);
            for (int j = 0; j < 3; j++) begin
               s3_rm_ff[i][j] <= RW'(s2_ab_ff[i][j][0]) + RW'(s2_ab_ff[i][j][1])
                               + RW'(s2_ab_ff[i][j][2]);
               s4_cp_ff[i][j][0] <= XW'(s3_t_ff[(i+2)%3]) * XW'(s3_rm_ff[(i+1)%3][j]);
               s4_cp_ff[i][j][1] <= XW'(s3_t_ff[(i+1)%3]) * XW'(s3_rm_ff[(i+2)%3][j]);
               for (int x = 0; x < 3; x++) begin
                  // pa: ea[x]*|rm[i][j]| stored as [x][i][j], pb: eb[x]*|rm[i][j]| stored as [i][j][x]
                  s4_pa_ff[x][i][j] <= EW'(s3_ea_ff[x]) * EW'(s4_rmag[i][j]);
                  s4_pb_ff[i][j][x] <= EW'(s3_eb_ff[x]) * EW'(s4_rmag[i][j]);
               end
            end
         end
         s5_lhs_ff <= s5_lhs_in;
         s5_rhs_ff <= s5_rhs_in;
         overlap_ff <= overlap_in;
      end
   end

`ifndef SYNTHESIS
   ready_tracks_output: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready does not follow output register state");
   last_stage_reaches_output: assert property (@(posedge clock) disable iff (reset)
      enable && valid_ff[4] |=> rsp_tvalid)
      else $error("item lost between last stage and output");
   stall_freezes_pipe: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(valid_ff))
      else $error("pipeline moved during stall");
   reset_empties_pipe: assert property (@(posedge clock)
      reset |=> valid_ff == '0)
      else $error("pipeline not empty after reset");
`endif
endmodule
`default_nettype wire
